/* hw/rtl/scic_pkg.sv */
// Shared constants and types for the sound chip interrupt controller.
// No dependencies; imported by sound_chip_interrupt_controller_top.
`default_nettype none

package scic_pkg;

  localparam int SOURCE_COUNT_DEF    = 11;
  localparam int SAMPLE_DONE_BIT_DEF = 10;

  // Software interrupt bit that a pending-register write may set.
  localparam int SOFT_BIT      = 5;
  // Sources at or above this bit share its level map bit.
  localparam int LEVEL_TOP_BIT = 7;
  localparam int LEVEL_SLOTS   = LEVEL_TOP_BIT + 1;

  localparam int REQ_W   = 4;
  localparam int DATA_W  = 11;
  localparam int LEVEL_W = 3;
  localparam int MAP_W   = LEVEL_SLOTS;
  localparam int CFG_IDX_W = 2;

  localparam int IN_BITS   = REQ_W + DATA_W;
  localparam int IN_TDW    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 3 * DATA_W + LEVEL_W + 1;
  localparam int OUT_TDW   = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK       = 4'd0,
    REQ_ARM_EN_WR  = 4'd1,
    REQ_ARM_PND_WR = 4'd2,
    REQ_ARM_CLR    = 4'd3,
    REQ_MAIN_EN_WR = 4'd4,
    REQ_MAIN_PND_WR = 4'd5,
    REQ_MAIN_CLR   = 4'd6,
    REQ_ARM_RAISE  = 4'd7,
    REQ_MAIN_RAISE = 4'd8
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_BIT0 = 2'd0,
    CFG_LEVEL_BIT1 = 2'd1,
    CFG_LEVEL_BIT2 = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

/* hw/rtl/sound_chip_interrupt_controller_top.sv */
// Sound chip interrupt controller: enable/pending registers for the coprocessor
// and main CPU sides, level encoder and stream ports. Depends on scic_pkg.
// One input word in, one result word out; every request produces a result.
`default_nettype none

// Each input word is a request (tick, enable write, pending write, clear or
// raise) applied to one side's registers; the block returns one result word
// per request, showing the state after it. An accepted word is held in the
// input register, then the register update, the lowest-active-bit level
// encoder and the main line are evaluated in one pass into the result
// register. A new word can be taken every cycle while
// results flow; while a result waits on out_tready the input register takes
// one more word, and in_tready then stays low until the result is taken.
// Level map registers are written over the cfg port, which is always ready;
// index 3 is ignored.
module sound_chip_interrupt_controller_top
  import scic_pkg::*;
#(
  parameter int SOURCE_COUNT    = SOURCE_COUNT_DEF,
  parameter int SAMPLE_DONE_BIT = SAMPLE_DONE_BIT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // in_tdata from bit 0: req_type[3:0], write_data[14:4], zero pad.
  input  wire logic [IN_TDW-1:0]    in_tdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // out_tdata from bit 0: arm_active_bits[10:0], arm_level[13:11],
  // main_irq[14], arm_pending_bits[25:15], main_pending_bits[36:26], zero pad.
  output logic [OUT_TDW-1:0]        out_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MAP_W-1:0]     cfg_data
);

  localparam int SC = SOURCE_COUNT;

  // Input stage.
  logic              s1_valid_r;
  logic [REQ_W-1:0]  s1_req_r;
  logic [DATA_W-1:0] s1_data_r;
  logic              s1_adv;

  // Interrupt state.
  logic [SC-1:0] arm_enable_r, arm_enable_nxt;
  logic [SC-1:0] arm_pending_r, arm_pending_nxt;
  logic [SC-1:0] main_enable_r, main_enable_nxt;
  logic [SC-1:0] main_pending_r, main_pending_nxt;

  logic [MAP_W-1:0] map0_r, map1_r, map2_r;

  // Result stage.
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_active_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_irq_r;
  logic [DATA_W-1:0]  out_arm_pnd_r;
  logic [DATA_W-1:0]  out_main_pnd_r;

  logic [SC-1:0]          data_ext;
  logic [SC-1:0]          active_nxt;
  logic [SC-1:0]          lowest;
  logic [LEVEL_SLOTS-1:0] slot;
  logic [LEVEL_W-1:0]     level_nxt;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r  <= in_tdata[REQ_W-1:0];
      s1_data_r <= in_tdata[IN_BITS-1:REQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map0_r <= '0;
      map1_r <= '0;
      map2_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEVEL_BIT0: map0_r <= cfg_data;
        CFG_LEVEL_BIT1: map1_r <= cfg_data;
        CFG_LEVEL_BIT2: map2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign data_ext = SC'(s1_data_r);

  always_comb begin
    arm_enable_nxt   = arm_enable_r;
    arm_pending_nxt  = arm_pending_r;
    main_enable_nxt  = main_enable_r;
    main_pending_nxt = main_pending_r;
    unique case (req_t'(s1_req_r))
      REQ_TICK:        arm_pending_nxt[SAMPLE_DONE_BIT] = 1'b1;
      REQ_ARM_EN_WR:   arm_enable_nxt = data_ext;
      REQ_ARM_PND_WR:  if (data_ext[SOFT_BIT]) arm_pending_nxt[SOFT_BIT] = 1'b1;
      REQ_ARM_CLR:     arm_pending_nxt = arm_pending_r & ~data_ext;
      REQ_MAIN_EN_WR:  main_enable_nxt = data_ext;
      REQ_MAIN_PND_WR: if (data_ext[SOFT_BIT]) main_pending_nxt[SOFT_BIT] = 1'b1;
      REQ_MAIN_CLR:    main_pending_nxt = main_pending_r & ~data_ext;
      REQ_ARM_RAISE:   arm_pending_nxt = arm_pending_r | data_ext;
      REQ_MAIN_RAISE:  main_pending_nxt = main_pending_r | data_ext;
      default: ;
    endcase
  end

  // Isolate the lowest active bit, then fold everything at or above the top
  // level slot into that slot before looking up the three map registers.
  assign active_nxt = arm_enable_nxt & arm_pending_nxt;
  assign lowest     = active_nxt & (~active_nxt + SC'(1));
  assign slot       = {|lowest[SC-1:LEVEL_TOP_BIT], lowest[LEVEL_TOP_BIT-1:0]};
  assign level_nxt  = {|(slot & map2_r), |(slot & map1_r), |(slot & map0_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_enable_r   <= '0;
      arm_pending_r  <= '0;
      main_enable_r  <= '0;
      main_pending_r <= '0;
    end else if (s1_adv) begin
      arm_enable_r   <= arm_enable_nxt;
      arm_pending_r  <= arm_pending_nxt;
      main_enable_r  <= main_enable_nxt;
      main_pending_r <= main_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_active_r   <= DATA_W'(active_nxt);
      out_level_r    <= level_nxt;
      out_irq_r      <= |(main_enable_nxt & main_pending_nxt);
      out_arm_pnd_r  <= DATA_W'(arm_pending_nxt);
      out_main_pnd_r <= DATA_W'(main_pending_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDW'({out_main_pnd_r, out_arm_pnd_r, out_irq_r,
                                out_level_r, out_active_r});

  // A nonzero level needs at least one active bit.
  a_level_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_level_r == '0 || out_active_r != '0))
    else $error("nonzero arm level with no active bits");

  // A tick always leaves the sample-done bit pending.
  a_tick_sets_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_req_r == REQ_TICK) |=> arm_pending_r[SAMPLE_DONE_BIT])
    else $error("tick did not set sample-done pending bit");

  // The main line in the result follows the registers it was taken from.
  a_main_irq_match: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_irq_r == |(main_enable_r & main_pending_r)))
    else $error("main_irq does not match main enable and pending");

  // A stalled input stage must not take a new word.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_tready)
    else $error("input stage overrun");

endmodule

`default_nettype wire

/* tb/sound_chip_interrupt_controller_top_test.sv */
// Self-checking test of sound_chip_interrupt_controller_top: directed table, then random requests
// under several level map settings, each result word checked against a local predictor.
// Depends on scic_pkg and the block itself.
`timescale 1ns / 1ps

module sound_chip_interrupt_controller_top_test;
  import scic_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 80;
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 4'd9;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 4'd15;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // Same bit order as out_tdata: the last field sits in the lowest bits.
  typedef struct packed {
    logic [DATA_W-1:0]  main_pnd;
    logic [DATA_W-1:0]  arm_pnd;
    logic               irq;
    logic [LEVEL_W-1:0] level;
    logic [DATA_W-1:0]  active;
  } irq_report_t;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [DATA_W-1:0] data;
    bit                typed;
    irq_report_t       report;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic [IN_TDW-1:0]    in_tdata   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [OUT_TDW-1:0]   out_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [MAP_W-1:0]     cfg_data   = '0;

  // Predictor copy of the block's registers.
  logic [DATA_W-1:0] arm_en, arm_pnd, main_en, main_pnd;
  logic [MAP_W-1:0]  level_map [0:2];

  irq_report_t irq_reports_due [$];
  int          mismatch_count = 0;
  bit          gaps_on = 1'b1;

  // With the identity maps below, the level of source i is i, saturating at 7.
  // Reports are written as {main pending, arm pending, main irq, level, arm active}.
  stim_row_t dir_rows [0:21] = '{
    '{REQ_UNUSED_LAST, 11'h7FF, 1'b1, {11'h000, 11'h000, 1'b0, 3'd0, 11'h000}},
    '{REQ_TICK,        11'h000, 1'b1, {11'h000, 11'h400, 1'b0, 3'd0, 11'h000}},
    '{REQ_ARM_PND_WR,  11'h7DF, 1'b1, {11'h000, 11'h400, 1'b0, 3'd0, 11'h000}},
    '{REQ_ARM_PND_WR,  11'h020, 1'b1, {11'h000, 11'h420, 1'b0, 3'd0, 11'h000}},
    '{REQ_ARM_EN_WR,   11'h7FF, 1'b1, {11'h000, 11'h420, 1'b0, 3'd5, 11'h420}},
    '{REQ_ARM_RAISE,   11'h7FF, 1'b1, {11'h000, 11'h7FF, 1'b0, 3'd0, 11'h7FF}},
    '{REQ_ARM_CLR,     11'h0FF, 1'b1, {11'h000, 11'h700, 1'b0, 3'd7, 11'h700}},
    '{REQ_ARM_CLR,     11'h7FF, 1'b1, {11'h000, 11'h000, 1'b0, 3'd0, 11'h000}},
    '{REQ_MAIN_EN_WR,  11'h7FF, 1'b1, {11'h000, 11'h000, 1'b0, 3'd0, 11'h000}},
    '{REQ_MAIN_PND_WR, 11'h020, 1'b1, {11'h020, 11'h000, 1'b1, 3'd0, 11'h000}},
    '{REQ_MAIN_RAISE,  11'h401, 1'b0, '0},
    '{REQ_MAIN_CLR,    11'h7FF, 1'b1, {11'h000, 11'h000, 1'b0, 3'd0, 11'h000}},
    '{REQ_MAIN_RAISE,  11'h7FF, 1'b1, {11'h7FF, 11'h000, 1'b1, 3'd0, 11'h000}},
    '{REQ_MAIN_EN_WR,  11'h000, 1'b0, '0},
    '{REQ_MAIN_PND_WR, 11'h7FF, 1'b0, '0},
    '{REQ_ARM_RAISE,   11'h080, 1'b0, '0},
    '{REQ_ARM_EN_WR,   11'h400, 1'b0, '0},
    '{REQ_TICK,        11'h000, 1'b0, '0},
    '{REQ_UNUSED_FIRST, 11'h7FF, 1'b0, '0},
    '{REQ_MAIN_CLR,    11'h000, 1'b0, '0},
    '{REQ_ARM_RAISE,   11'h002, 1'b0, '0},
    '{REQ_ARM_EN_WR,   11'h2AA, 1'b0, '0}
  };

  sound_chip_interrupt_controller_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // Applies one request to the predictor registers and returns the report it causes.
  function automatic irq_report_t apply_request(input logic [REQ_W-1:0] req,
                                                input logic [DATA_W-1:0] data);
    irq_report_t rep;
    int          slot;
    bit          found;
    case (req)
      REQ_TICK:        arm_pnd[SAMPLE_DONE_BIT_DEF] = 1'b1;
      REQ_ARM_EN_WR:   arm_en = data;
      REQ_ARM_PND_WR:  if (data[SOFT_BIT]) arm_pnd[SOFT_BIT] = 1'b1;
      REQ_ARM_CLR:     arm_pnd &= ~data;
      REQ_MAIN_EN_WR:  main_en = data;
      REQ_MAIN_PND_WR: if (data[SOFT_BIT]) main_pnd[SOFT_BIT] = 1'b1;
      REQ_MAIN_CLR:    main_pnd &= ~data;
      REQ_ARM_RAISE:   arm_pnd |= data;
      REQ_MAIN_RAISE:  main_pnd |= data;
      default: ;
    endcase
    rep.active   = arm_en & arm_pnd;
    rep.irq      = |(main_en & main_pnd);
    rep.arm_pnd  = arm_pnd;
    rep.main_pnd = main_pnd;
    rep.level    = '0;
    found        = 1'b0;
    // The lowest active source picks the level; sources above 7 share slot 7.
    for (int i = 0; i < DATA_W; i++) begin
      if (!found && rep.active[i]) begin
        found     = 1'b1;
        slot      = (i > LEVEL_TOP_BIT) ? LEVEL_TOP_BIT : i;
        rep.level = {level_map[2][slot], level_map[1][slot], level_map[0][slot]};
      end
    end
    return rep;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic logic [REQ_W-1:0] pick_req();
    if ($urandom_range(0, 99) < 6) return REQ_W'($urandom_range(REQ_UNUSED_FIRST,
                                                                REQ_UNUSED_LAST));
    return REQ_W'($urandom_range(REQ_TICK, REQ_MAIN_RAISE));
  endfunction

  function automatic logic [DATA_W-1:0] pick_data(input logic [REQ_W-1:0] req);
    int                form;
    logic [DATA_W-1:0] d;
    form = $urandom_range(0, 99);
    if (form < 25)      d = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
    else if (form < 32) d = '0;
    else if (form < 39) d = '1;
    else                d = DATA_W'($urandom);
    // Sparse clear masks keep some pending bits alive between clears.
    if ((req == REQ_ARM_CLR || req == REQ_MAIN_CLR) && form >= 39)
      d = DATA_W'($urandom & $urandom);
    if ((req == REQ_ARM_PND_WR || req == REQ_MAIN_PND_WR) && $urandom_range(0, 1) == 1)
      d[SOFT_BIT] = 1'b1;
    return d;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic push_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] data,
                              input bit typed, input irq_report_t typed_report);
    int          gap;
    irq_report_t rep;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= IN_TDW'({data, req});
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rep = apply_request(req, data);
    irq_reports_due.push_back(typed ? typed_report : rep);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (irq_reports_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_level_maps(input logic [MAP_W-1:0] m0, input logic [MAP_W-1:0] m1,
                                  input logic [MAP_W-1:0] m2, input bit poke_unused);
    logic [MAP_W-1:0] vals [0:3];
    vals = '{m0, m1, m2, MAP_W'($urandom)};
    for (int i = 0; i < (poke_unused ? 4 : 3); i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (CFG_IDX_W'(i) != CFG_UNUSED_IDX) level_map[i] = vals[i];
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    irq_report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[OUT_BITS-1:0];
      if (irq_reports_due.size() == 0) begin
        $display("%0t ns: result word with none expected, actual %0h", $time, got);
        mismatch_count++;
      end else begin
        want = irq_reports_due.pop_front();
        check_field("arm_active_bits",   want.active,   got.active);
        check_field("arm_level",         DATA_W'(want.level), DATA_W'(got.level));
        check_field("main_irq",          DATA_W'(want.irq),   DATA_W'(got.irq));
        check_field("arm_pending_bits",  want.arm_pnd,  got.arm_pnd);
        check_field("main_pending_bits", want.main_pnd, got.main_pnd);
      end
    end
  end

  // Result side back-pressure: calm stretches alternate with stretches of random stalls.
  int  stall_left = 0;
  int  mode_left  = 100;
  bit  stalling   = 1'b0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stalling  = ~stalling;
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (stalling && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                  : $urandom_range(5, 25);
    end
  end

  initial begin
    logic [REQ_W-1:0] req;
    arm_en   = '0;
    arm_pnd  = '0;
    main_en  = '0;
    main_pnd = '0;
    level_map = '{'0, '0, '0};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_level_maps(8'hAA, 8'hCC, 8'hF0, 1'b1);
    foreach (dir_rows[i])
      push_request(dir_rows[i].req, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].report);

    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: write_level_maps(8'h00, 8'h00, 8'h00, 1'b0);
        1: write_level_maps(8'hFF, 8'hFF, 8'hFF, 1'b0);
        3: write_level_maps(8'hF0, 8'hCC, 8'hAA, 1'b1);
        default: write_level_maps(MAP_W'($urandom), MAP_W'($urandom), MAP_W'($urandom), 1'b0);
      endcase
      gaps_on = (phase != 2);
      repeat (PHASE_ITEMS) begin
        req = pick_req();
        push_request(req, pick_data(req), 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (irq_reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* sound_chip_interrupt_controller_top.f */
hw/rtl/scic_pkg.sv
hw/rtl/sound_chip_interrupt_controller_top.sv
tb/sound_chip_interrupt_controller_top_test.sv
